// ----- design/pq2k_pkg.sv -----
// ----------------------------------------------------------------------------
// pq2k_pkg
// Shared types, command codes and ordering function for the two-key
// priority queue.
// ----------------------------------------------------------------------------
package pq2k_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int MODE_W     = 2;
    localparam int TAG_W      = 32;
    localparam int ROLL_W     = 16;
    localparam int MARKS_W    = 16;

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd2;

    // packed with the tag in the lowest bits
    typedef struct packed {
        logic [MARKS_W-1:0] marks;
        logic [ROLL_W-1:0]  roll;
        logic [TAG_W-1:0]   tag;
    } pq2k_entry_t;

    // command broadcast to every cell
    typedef struct packed {
        logic        push;
        logic        pop;
        pq2k_entry_t entry;
    } pq2k_cmd_t;

    // true when a is served strictly before b
    function automatic logic pq2k_before(input pq2k_entry_t a, input pq2k_entry_t b);
        logic res;
        if (a.marks != b.marks) begin
            res = (a.marks > b.marks);
        end else begin
            res = (a.roll < b.roll);
        end
        return res;
    endfunction

endpackage

// ----- design/max_priority_queue_two_key.sv -----
// ----------------------------------------------------------------------------
// max_priority_queue_two_key
// Bounded priority queue kept as a sorted row of register cells, best first.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries commands: s_tuser holds the mode (push, peek, pop),
//   s_tdata the entry to push. Every command yields exactly one item on the
//   m_ channel describing the top after the command.
//   Ordering: more marks first, then smaller roll, then earlier push.
//   m_tvalid rises in the cycle after acceptance. One command per cycle
//   is taken while the result register is empty or being drained: every
//   cell decides its next entry from its own compare and its neighbours
//   combinationally, so push and pop each update the whole row together.
//   A push to a full queue is dropped and flagged by overflow; a pop of an
//   empty queue changes nothing. When empty, has_top is 0 and data is zero.
//   Reset empties the queue at once (occupancy cleared, cells untouched) and
//   drops any pending result. While the receiver stalls, the held result
//   stays put and s_tready is low.
// ----------------------------------------------------------------------------
module max_priority_queue_two_key #(
    parameter int CAPACITY = pq2k_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // entry_tag, entry_roll, entry_marks
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // top_tag, top_roll, top_marks
    output logic [1:0]  m_tuser    // has_top, overflow
);
    import pq2k_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             ovf_reg;
    logic             ovf_next;

    logic             accept;
    logic             full;
    logic             empty;
    logic [1:0]       mode;
    pq2k_cmd_t        cmd;

    pq2k_entry_t      cell_entry [CAPACITY];
    logic             cell_flag  [CAPACITY];

    assign mode     = s_tuser;
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (occ_reg == OCC_W'(CAPACITY));
    assign empty    = (occ_reg == '0);

    assign cmd.push        = accept && (mode == MODE_PUSH) && !full;
    assign cmd.pop         = accept && (mode == MODE_POP) && !empty;
    assign cmd.entry.tag   = s_tdata[31:0];
    assign cmd.entry.roll  = s_tdata[47:32];
    assign cmd.entry.marks = s_tdata[63:48];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic        lf;
            pq2k_entry_t le;
            pq2k_entry_t re;
            if (gi == 0) begin : g_first
                assign lf = 1'b0;
                assign le = cmd.entry;
            end else begin : g_mid
                assign lf = cell_flag[gi-1];
                assign le = cell_entry[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign re = cell_entry[gi];
            end else begin : g_inner
                assign re = cell_entry[gi+1];
            end
            pq2k_cell #(
                .OCC_W (OCC_W),
                .INDEX (gi)
            ) u_cell (
                .aclk        (aclk),
                .cmd         (cmd),
                .occupancy   (occ_reg),
                .left_flag   (lf),
                .left_entry  (le),
                .right_entry (re),
                .flag        (cell_flag[gi]),
                .entry       (cell_entry[gi])
            );
        end
    endgenerate

    always_comb begin
        occ_next     = occ_reg;
        m_valid_next = m_valid_reg;
        ovf_next     = ovf_reg;
        if (cmd.push) begin
            occ_next = occ_reg + OCC_W'(1);
        end else if (cmd.pop) begin
            occ_next = occ_reg - OCC_W'(1);
        end
        if (accept) begin
            m_valid_next = 1'b1;
            ovf_next     = (mode == MODE_PUSH) && full;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
            ovf_reg     <= 1'b0;
        end else begin
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
            ovf_reg     <= ovf_next;
        end
    end

    // result reads the head cell directly; state is frozen while stalled
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = empty ? 64'd0 : cell_entry[0];
    assign m_tuser  = {ovf_reg, !empty};

    // occupancy stays within the row
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    // a dropped push leaves the queue as it was
    a_ovf_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mode == MODE_PUSH && full) |=> (occ_reg == $past(occ_reg)))
        else $error("overflowed push changed occupancy");

    // an overflow result always reports a top
    a_ovf_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && ovf_reg) |-> !empty)
        else $error("overflow reported on empty queue");

    // a pop of a nonempty queue removes exactly one entry
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |=> (occ_reg == $past(occ_reg) - OCC_W'(1)))
        else $error("pop miscounted");

endmodule

// ----- design/pq2k_cell.sv -----
// ----------------------------------------------------------------------------
// pq2k_cell
// One slot of the sorted register row: holds an entry, shifts right on an
// insert ahead of it and takes its right neighbour on a pop.
// ----------------------------------------------------------------------------
module pq2k_cell #(
    parameter int OCC_W = 7,
    parameter int INDEX = 0
) (
    input  logic                    aclk,
    input  pq2k_pkg::pq2k_cmd_t     cmd,
    input  logic [OCC_W-1:0]        occupancy,
    input  logic                    left_flag,
    input  pq2k_pkg::pq2k_entry_t   left_entry,
    input  pq2k_pkg::pq2k_entry_t   right_entry,
    output logic                    flag,
    output pq2k_pkg::pq2k_entry_t   entry
);
    import pq2k_pkg::*;

    pq2k_entry_t entry_reg;
    pq2k_entry_t entry_next;
    logic        valid;

    assign valid = (occupancy > OCC_W'(INDEX));

    // new entry lands at or before this slot; equal keys keep arrival order
    assign flag = !valid || pq2k_before(cmd.entry, entry_reg);

    always_comb begin
        entry_next = entry_reg;
        if (cmd.push) begin
            if (flag) begin
                entry_next = left_flag ? left_entry : cmd.entry;
            end
        end else if (cmd.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the two-key max priority queue. A scoreboard keeps its
// own sorted copy of the queue, predicts the top report for every accepted
// command and compares each result item against it, in order. A short
// directed opening is followed by random fill, drain and mixed phases under
// random sender bursts and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import pq2k_pkg::*;

    localparam int DEPTH        = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1950;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    // spare mode code, handled by the block as a peek
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_MOSTLY} ready_style_t;
    typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} phase_kind_t;

    typedef struct {
        bit          has_top;
        pq2k_entry_t top;
        bit          overflow;
    } top_report_t;

    class pq_scoreboard;
        pq2k_entry_t ranked[$];
        top_report_t awaited[$];
        int unsigned n_commands;
        int unsigned n_results;
        int unsigned n_overflows;
        int unsigned n_empty;
        int unsigned n_ties;
        int unsigned peak;
        int unsigned n_errors;

        // strictly ahead: more marks, or equal marks and a smaller roll
        function bit outranks(pq2k_entry_t a, pq2k_entry_t b);
            if (a.marks != b.marks) begin
                return a.marks > b.marks;
            end
            return a.roll < b.roll;
        endfunction

        function void note_command(logic [MODE_W-1:0] mode, pq2k_entry_t e);
            top_report_t rep;
            int          pos;
            rep.overflow = 1'b0;
            n_commands++;
            if (mode == MODE_PUSH) begin
                if (ranked.size() >= DEPTH) begin
                    rep.overflow = 1'b1;
                    n_overflows++;
                end else begin
                    pos = 0;
                    while (pos < ranked.size() && !outranks(e, ranked[pos])) begin
                        if (ranked[pos].marks == e.marks && ranked[pos].roll == e.roll) begin
                            n_ties++;
                        end
                        pos++;
                    end
                    ranked.insert(pos, e);
                end
            end else if (mode == MODE_POP) begin
                if (ranked.size() > 0) begin
                    void'(ranked.pop_front());
                end
            end
            if (ranked.size() > 0) begin
                rep.has_top = 1'b1;
                rep.top     = ranked[0];
            end else begin
                rep.has_top = 1'b0;
                rep.top     = '0;
                n_empty++;
            end
            if (ranked.size() > peak) begin
                peak = ranked.size();
            end
            awaited.push_back(rep);
        endfunction

        function void check_result(logic [63:0] data, logic [1:0] flags);
            top_report_t want;
            pq2k_entry_t got;
            got = data;
            n_results++;
            if (awaited.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("result %0d arrived with nothing outstanding: tdata=%h tuser=%b",
                             n_results, data, flags);
                end
                return;
            end
            want = awaited.pop_front();
            if (flags[0] !== want.has_top || got.tag !== want.top.tag ||
                got.roll !== want.top.roll || got.marks !== want.top.marks ||
                flags[1] !== want.overflow) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("mismatch on result %0d: expected has_top=%0b tag=%h roll=%h",
                             n_results, want.has_top, want.top.tag, want.top.roll);
                    $display("    marks=%h overflow=%0b, got has_top=%0b tag=%h roll=%h",
                             want.top.marks, want.overflow, flags[0], got.tag, got.roll);
                    $display("    marks=%h overflow=%0b", got.marks, flags[1]);
                end
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // entry_tag, entry_roll, entry_marks
    logic [1:0]  s_tuser  = '0;   // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // top_tag, top_roll, top_marks
    logic [1:0]  m_tuser;         // has_top, overflow

    pq_scoreboard sb = new();

    int burst_left  = 1;
    int hold_asks   = 0;
    int hold_served = 0;

    max_priority_queue_two_key u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // both channels are sampled with pre-edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
            end
            if (s_tvalid && s_tready) begin
                sb.note_command(s_tuser, s_tdata);
            end
        end
    end

    function automatic pq2k_entry_t make_entry(logic [31:0] tag, logic [15:0] roll,
                                               logic [15:0] marks);
        pq2k_entry_t e;
        e.tag   = tag;
        e.roll  = roll;
        e.marks = marks;
        return e;
    endfunction

    // two thirds of the keys take their marks from tiny ranges, and a third also their roll, so that ties are common
    function automatic pq2k_entry_t random_entry();
        pq2k_entry_t e;
        int          pick;
        pick    = $urandom_range(0, 2);
        e.tag   = $urandom;
        e.roll  = 16'($urandom);
        e.marks = 16'($urandom);
        if (pick == 1) begin
            e.marks = 16'($urandom_range(0, 3));
        end else if (pick == 2) begin
            e.marks = 16'(32'hffff - $urandom_range(0, 1));
            e.roll  = 16'($urandom_range(0, 2));
        end
        return e;
    endfunction

    task automatic send_command(logic [MODE_W-1:0] mode, pq2k_entry_t e);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= e;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // sender stops until every outstanding result is back
    task automatic drain_wait();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // receiver: stall patterns in stretches, plus a long hold when asked
    initial begin
        ready_style_t style;
        int           span;
        int           k;
        forever begin
            style = ready_style_t'($urandom_range(0, 3));
            span  = $urandom_range(20, 150);
            for (k = 0; k < span; k++) begin
                @(posedge aclk);
                if (hold_asks != hold_served) begin
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                    hold_served = hold_served + 1;
                end
                case (style)
                    RDY_ALWAYS: begin
                        m_tready <= 1'b1;
                    end
                    RDY_COIN: begin
                        m_tready <= 1'($urandom_range(0, 1));
                    end
                    RDY_SPARSE: begin
                        m_tready <= (k % 4 == 0);
                    end
                    default: begin
                        m_tready <= ($urandom_range(0, 7) != 0);
                    end
                endcase
            end
        end
    end

    initial begin
        #(12 * 400000);
        $display("FAIL max_priority_queue_two_key");
        $finish;
    end

    initial begin
        phase_kind_t      kind;
        logic [MODE_W-1:0] mode;
        int               seg;
        int               sent;
        int               span;
        int               push_pct;
        int               pick;
        int               k;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // empty queue: pop, peek and the spare mode all report no top
        send_command(MODE_POP,   make_entry(32'h1111_1111, 16'h0001, 16'h0001));
        send_command(MODE_PEEK,  make_entry(32'h2222_2222, 16'h0002, 16'h0002));
        send_command(MODE_SPARE, make_entry(32'h3333_3333, 16'h0003, 16'h0003));
        send_command(MODE_PUSH,  make_entry(32'h0000_0000, 16'h0000, 16'h0000));
        send_command(MODE_PUSH,  make_entry(32'hffff_ffff, 16'hffff, 16'hffff));
        // equal marks, smaller roll takes the top
        send_command(MODE_PUSH,  make_entry(32'haaaa_5555, 16'h0000, 16'hffff));
        // exact tie stays behind the earlier push
        send_command(MODE_PUSH,  make_entry(32'h5555_aaaa, 16'h0000, 16'hffff));
        send_command(MODE_PEEK,  make_entry(32'h0f0f_0f0f, 16'h0f0f, 16'h0f0f));
        send_command(MODE_SPARE, make_entry(32'hf0f0_f0f0, 16'hf0f0, 16'hf0f0));
        send_command(MODE_PUSH,  make_entry(32'h8000_0001, 16'h1234, 16'h8000));
        send_command(MODE_PUSH,  make_entry(32'h7fff_fffe, 16'h0000, 16'h7fff));
        send_command(MODE_POP,   make_entry(32'h0, 16'h0, 16'h0));
        send_command(MODE_POP,   make_entry(32'h0, 16'h0, 16'h0));
        send_command(MODE_POP,   make_entry(32'h0, 16'h0, 16'h0));
        send_command(MODE_POP,   make_entry(32'h0, 16'h0, 16'h0));
        send_command(MODE_POP,   make_entry(32'h0, 16'h0, 16'h0));
        send_command(MODE_POP,   make_entry(32'h0, 16'h0, 16'h0));
        // already empty again
        send_command(MODE_POP,   make_entry(32'hdead_beef, 16'hbeef, 16'hdead));
        drain_wait();

        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS) begin
            if (seg == 0) begin
                kind = SEG_FILL;
                span = 90;
            end else begin
                kind = phase_kind_t'($urandom_range(0, 2));
                span = $urandom_range(30, 120);
            end
            case (kind)
                SEG_FILL:  push_pct = 90;
                SEG_DRAIN: push_pct = 10;
                default:   push_pct = 50;
            endcase
            // receiver holds off while the sender keeps offering
            if (seg == 3 || seg == 11) begin
                hold_asks = hold_asks + 1;
            end
            for (k = 0; k < span; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < push_pct) begin
                    mode = MODE_PUSH;
                end else begin
                    pick = $urandom_range(0, 19);
                    if (pick < 15) begin
                        mode = MODE_POP;
                    end else if (pick < 19) begin
                        mode = MODE_PEEK;
                    end else begin
                        mode = MODE_SPARE;
                    end
                end
                send_command(mode, random_entry());
                sent++;
            end
            seg++;
            if (seg % 5 == 0) begin
                drain_wait();
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (4) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.n_errors += sb.pending();
        end

        $display("covered %0d commands in %0d phases: %0d dropped pushes, %0d empty reports,",
                 sb.n_commands, seg, sb.n_overflows, sb.n_empty);
        $display("    %0d exact ties, peak occupancy %0d, %0d failures",
                 sb.n_ties, sb.peak, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("PASS max_priority_queue_two_key");
        end else begin
            $display("FAIL max_priority_queue_two_key");
        end
        $finish;
    end

endmodule
